[src/dsst_pkg.sv]
// ============================================================================
// Disk scan seek timer package
// Shared widths, codes, types and the restoring-division step.
// ============================================================================
package dsst_pkg;

    // Field widths
    localparam int REQ_W      = 11;
    localparam int TIME_W     = 32;
    localparam int TRK_W      = 5;
    localparam int SEC_W      = 7;
    localparam int NT_W       = 6;
    localparam int NS_W       = 7;
    localparam int DLY_W      = 16;
    localparam int INC_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Parameter defaults
    localparam int DEFAULT_MAX_TRACKS  = 32;
    localparam int DEFAULT_MAX_SECTORS = 64;

    // Largest sector count the seven-bit register can hold
    localparam int SEC_REG_MAX = 127;

    // Result count limit per request
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 6;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MOVED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_TRACKS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SECTORS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_DELAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_DELAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_INCREMENT = 3'd4;

    // Effective configuration seen by the front and the back
    typedef struct packed {
        logic [NT_W-1:0]  tracks;
        logic [NS_W-1:0]  secs;
        logic [DLY_W-1:0] trk_step_time;
        logic [DLY_W-1:0] sector_delay;
        logic [INC_W-1:0] inc_raw;
    } cfg_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [TRK_W-1:0] ttrack;
        logic [SEC_W-1:0] tsec;
        logic [SEC_W-1:0] inc;
        logic             out_of_range;
    } cmd_t;

    // One restoring-division step: shift in one dividend bit and subtract
    // the divisor when it fits. Returns the quotient bit over the remainder.
    function automatic logic [SEC_W:0] div_step(
        input logic [SEC_W-1:0] rem,
        input logic             bit_in,
        input logic [NS_W-1:0]  d
    );
        logic [SEC_W:0] trial;
        logic [SEC_W:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            return {1'b1, diff[SEC_W-1:0]};
        end
        return {1'b0, trial[SEC_W-1:0]};
    endfunction

endpackage

[src/dsst_ifs.sv]
// ============================================================================
// Disk scan seek timer channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ============================================================================

// Request channel: one linear sector number per request
interface dsst_req_if import dsst_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] sector_request;

    modport source (output valid, output sector_request, input ready);
    modport sink (input valid, input sector_request, output ready);
endinterface

// Result channel: one visited position per result, one or more per request
interface dsst_res_if import dsst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    visited_position;
    logic [TIME_W-1:0]   elapsed_time;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output visited_position, output elapsed_time,
                    output status, output last, input ready);
    modport sink (input valid, input visited_position, input elapsed_time,
                  input status, input last, output ready);
endinterface

// Configuration write channel
interface dsst_cfg_if import dsst_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/dsst_front.sv]
// ============================================================================
// Disk scan seek timer front
// Accepts a request and splits it into track and sector with a bit-serial
// divider, reduces the sector increment alongside, and queues the result.
// ============================================================================
module dsst_front import dsst_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    dsst_req_if.sink      req,
    input  cfg_t          cfg,
    output logic          q_valid,
    input  logic          q_ready,
    output cmd_t          q_data
);

    localparam int BIT_W = $clog2(REQ_W);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_DIV  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [REQ_W-1:0] quot_reg, quot_next;
    logic [SEC_W-1:0] div_rem_reg, div_rem_next;
    logic [SEC_W-1:0] inc_rem_reg, inc_rem_next;
    logic [BIT_W-1:0] bit_idx_reg, bit_idx_next;

    logic [REQ_W-1:0] inc_ext;
    logic [SEC_W:0]   step_div;
    logic [SEC_W:0]   step_inc;

    // Both remainders share one bit counter; the increment is zero-extended.
    assign inc_ext  = {{(REQ_W-INC_W){1'b0}}, cfg.inc_raw};
    assign step_div = div_step(div_rem_reg, req_reg[bit_idx_reg], cfg.secs);
    assign step_inc = div_step(inc_rem_reg, inc_ext[bit_idx_reg], cfg.secs);

    assign req.ready = (state_reg == FS_IDLE);

    // Classified request toward the queue
    assign q_valid             = (state_reg == FS_PUSH);
    assign q_data.req          = req_reg;
    assign q_data.ttrack       = quot_reg[TRK_W-1:0];
    assign q_data.tsec         = div_rem_reg;
    assign q_data.inc          = inc_rem_reg;
    assign q_data.out_of_range = (quot_reg >= {{(REQ_W-NT_W){1'b0}}, cfg.tracks});

    // Sequencer: accept, divide one bit per cycle, push
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        quot_next    = quot_reg;
        div_rem_next = div_rem_reg;
        inc_rem_next = inc_rem_reg;
        bit_idx_next = bit_idx_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (req.valid)
                begin
                    req_next     = req.sector_request;
                    quot_next    = '0;
                    div_rem_next = '0;
                    inc_rem_next = '0;
                    bit_idx_next = BIT_W'(REQ_W - 1);
                    state_next   = FS_DIV;
                end
            end
            FS_DIV:
            begin
                quot_next    = {quot_reg[REQ_W-2:0], step_div[SEC_W]};
                div_rem_next = step_div[SEC_W-1:0];
                inc_rem_next = step_inc[SEC_W-1:0];
                if (bit_idx_reg == '0)
                begin
                    state_next = FS_PUSH;
                end
                else
                begin
                    bit_idx_next = bit_idx_reg - 1'b1;
                end
            end
            FS_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FS_IDLE;
            bit_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_idx_reg <= bit_idx_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        quot_reg    <= quot_next;
        div_rem_reg <= div_rem_next;
        inc_rem_reg <= inc_rem_next;
    end

endmodule

[src/dsst_queue.sv]
// ============================================================================
// Disk scan seek timer queue
// Short first-in first-out buffer of classified requests.
// ============================================================================
module dsst_queue import dsst_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/dsst_back.sv]
// ============================================================================
// Disk scan seek timer back
// Holds the head, walks it track by track under the sweep policy, performs
// the final rotation and drives the registered result channel.
// ============================================================================
module dsst_back import dsst_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          q_valid,
    output logic          q_ready,
    input  cmd_t          q_data,
    dsst_res_if.source    res
);

    localparam int NBIT_W = $clog2(SEC_W);
    localparam int PROD_W = SEC_W + DLY_W;

    localparam logic [2:0] BS_IDLE     = 3'd0;
    localparam logic [2:0] BS_NORM     = 3'd1;
    localparam logic [2:0] BS_CHECK    = 3'd2;
    localparam logic [2:0] BS_WALK     = 3'd3;
    localparam logic [2:0] BS_ROT_MUL  = 3'd4;
    localparam logic [2:0] BS_ROT_EMIT = 3'd5;

    logic [2:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [TRK_W-1:0]    head_track_reg, head_track_next;
    logic [SEC_W-1:0]    head_sector_reg, head_sector_next;
    logic                sweep_up_reg, sweep_up_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NBIT_W-1:0]   bit_reg, bit_next;
    logic [SEC_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                res_valid_reg, res_valid_next;
    logic [REQ_W-1:0]    pos_reg;
    logic [TIME_W-1:0]   time_out_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    logic                emit;
    logic [REQ_W-1:0]    emit_pos;
    logic [TIME_W-1:0]   emit_time;
    logic [STATUS_W-1:0] emit_status;
    logic                emit_last;
    logic                out_free;

    logic [SEC_W:0]      norm_step;
    logic [NT_W-1:0]     tracks_m1;
    logic                step_down;
    logic [TRK_W-1:0]    step_track;
    logic [SEC_W:0]      sec_sum;
    logic [SEC_W-1:0]    step_sector;
    logic [TIME_W-1:0]   step_time;
    logic                step_last;
    logic [SEC_W-1:0]    rot_span;

    // Linear position, kept to the width of the result field
    function automatic logic [REQ_W-1:0] lin_pos(
        input logic [TRK_W-1:0] trk,
        input logic [SEC_W-1:0] sec,
        input logic [NS_W-1:0]  secs
    );
        logic [TRK_W+NS_W-1:0] full;
        full = {{NS_W{1'b0}}, trk} * {{TRK_W{1'b0}}, secs}
             + {{TRK_W{1'b0}}, sec};
        return full[REQ_W-1:0];
    endfunction

    assign out_free = !res_valid_reg || res.ready;
    assign q_ready  = (state_reg == BS_IDLE);

    // Reduction of a stale head sector after a sector count change
    assign norm_step = div_step(rem_reg, head_sector_reg[bit_reg], cfg.secs);

    // One track step: reverse at either edge, rotate by the increment
    assign tracks_m1   = cfg.tracks - 1'b1;
    assign step_down   = sweep_up_reg ? ({1'b0, head_track_reg} >= tracks_m1)
                                      : (head_track_reg != '0);
    assign step_track  = step_down ? head_track_reg - 1'b1 : head_track_reg + 1'b1;
    assign sec_sum     = {1'b0, head_sector_reg} + {1'b0, cmd_reg.inc};
    assign step_sector = (sec_sum >= {1'b0, cfg.secs})
                       ? SEC_W'(sec_sum - {1'b0, cfg.secs}) : sec_sum[SEC_W-1:0];
    assign step_time   = time_reg + {{(TIME_W-DLY_W){1'b0}}, cfg.trk_step_time};
    assign step_last   = ((step_track == cmd_reg.ttrack) && (step_sector == cmd_reg.tsec))
                       || (cnt_reg == CNT_W'(RESULT_CAP - 1));

    // Forward rotation distance to the target sector
    assign rot_span = (cmd_reg.tsec >= head_sector_reg)
                    ? cmd_reg.tsec - head_sector_reg
                    : cmd_reg.tsec + cfg.secs - head_sector_reg;

    // Sequencer for one request
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        head_track_next  = head_track_reg;
        head_sector_next = head_sector_reg;
        sweep_up_next    = sweep_up_reg;
        time_next        = time_reg;
        cnt_next         = cnt_reg;
        bit_next         = bit_reg;
        rem_next         = rem_reg;
        prod_next        = prod_reg;
        emit             = 1'b0;
        emit_pos         = lin_pos(head_track_reg, head_sector_reg, cfg.secs);
        emit_time        = '0;
        emit_status      = ST_MOVED;
        emit_last        = 1'b1;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_data;
                    rem_next = '0;
                    bit_next = NBIT_W'(SEC_W - 1);
                    if (head_sector_reg >= cfg.secs)
                    begin
                        state_next = BS_NORM;
                    end
                    else
                    begin
                        state_next = BS_CHECK;
                    end
                end
            end
            BS_NORM:
            begin
                rem_next = norm_step[SEC_W-1:0];
                if (bit_reg == '0)
                begin
                    head_sector_next = norm_step[SEC_W-1:0];
                    state_next       = BS_CHECK;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            BS_CHECK:
            begin
                if (cmd_reg.out_of_range)
                begin
                    // Out of range: report the head, change nothing
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_RANGE;
                        state_next  = BS_IDLE;
                    end
                end
                else if ((cmd_reg.ttrack == head_track_reg) &&
                         (cmd_reg.tsec == head_sector_reg))
                begin
                    // Already there: a single result at the request itself
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_pos    = cmd_reg.req;
                        emit_status = ST_ALREADY;
                        time_next   = '0;
                        state_next  = BS_IDLE;
                    end
                end
                else
                begin
                    time_next = '0;
                    cnt_next  = '0;
                    if (cmd_reg.ttrack != head_track_reg)
                    begin
                        state_next = BS_WALK;
                    end
                    else
                    begin
                        state_next = BS_ROT_MUL;
                    end
                end
            end
            BS_WALK:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_pos         = lin_pos(step_track, step_sector, cfg.secs);
                    emit_time        = step_time;
                    emit_last        = step_last;
                    head_track_next  = step_track;
                    head_sector_next = step_sector;
                    sweep_up_next    = !step_down;
                    time_next        = step_time;
                    cnt_next         = cnt_reg + 1'b1;
                    if (step_last)
                    begin
                        state_next = BS_IDLE;
                    end
                    else if (step_track == cmd_reg.ttrack)
                    begin
                        state_next = BS_ROT_MUL;
                    end
                end
            end
            BS_ROT_MUL:
            begin
                prod_next  = {{DLY_W{1'b0}}, rot_span} * {{SEC_W{1'b0}}, cfg.sector_delay};
                state_next = BS_ROT_EMIT;
            end
            BS_ROT_EMIT:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_time        = time_reg + {{(TIME_W-PROD_W){1'b0}}, prod_reg};
                    emit_pos         = lin_pos(head_track_reg, cmd_reg.tsec, cfg.secs);
                    time_next        = emit_time;
                    head_sector_next = cmd_reg.tsec;
                    state_next       = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Output register valid: set on a new result, cleared when taken
    always_comb
    begin
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control state and head state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BS_IDLE;
            head_track_reg  <= '0;
            head_sector_reg <= '0;
            sweep_up_reg    <= 1'b1;
            time_reg        <= '0;
            cnt_reg         <= '0;
            bit_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_track_reg  <= head_track_next;
            head_sector_reg <= head_sector_next;
            sweep_up_reg    <= sweep_up_next;
            time_reg        <= time_next;
            cnt_reg         <= cnt_next;
            bit_reg         <= bit_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Datapath and result payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        rem_reg  <= rem_next;
        prod_reg <= prod_next;
        if (emit)
        begin
            pos_reg      <= emit_pos;
            time_out_reg <= emit_time;
            status_reg   <= emit_status;
            last_reg     <= emit_last;
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.visited_position = pos_reg;
    assign res.elapsed_time     = time_out_reg;
    assign res.status           = status_reg;
    assign res.last             = last_reg;

`ifndef NO_ASSERTIONS
    // Once reduced, the head sector stays below the sector count while moving.
    a_sector_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_WALK || state_reg == BS_ROT_MUL || state_reg == BS_ROT_EMIT)
        |-> (head_sector_reg < cfg.secs))
        else $error("head sector not reduced below the sector count");

    // The final rotation only starts on the target track.
    a_rotate_on_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_ROT_MUL || state_reg == BS_ROT_EMIT)
        |-> (head_track_reg == cmd_reg.ttrack))
        else $error("rotation started off the target track");

    // An out-of-range request never moves the head.
    a_no_walk_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_WALK) |-> !cmd_reg.out_of_range)
        else $error("head walking for an out-of-range request");

    // Single-result outcomes always close the request.
    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (status_reg != ST_MOVED)) |-> last_reg)
        else $error("status result without last");
`endif

endmodule

[src/disk_scan_seek_timer_core.sv]
// ============================================================================
// Disk scan seek timer core
// Elevator-policy disk head model: splits each sector request, walks the
// head track by track and reports every visited position with its time.
// ============================================================================
// Each request is split into track and sector by an eleven-step bit-serial
// divider in the front: a request enters a two-entry queue from the push
// state once the division is done, and the front takes no new request
// until it has pushed the last one. The back then picks it up, classifies
// it (first reducing the head sector if the sector count was lowered since
// the head last moved), emits one result per track step, and performs the
// final rotation, which includes one registered multiply. At the default
// geometry a seek walks at most 61 tracks. Short seeks run at the pace of
// the front, long seeks at the pace of the back. Results leave through an
// output register and wait there while the sink stalls; the queue lets the
// front split the next request meanwhile. Configuration writes are always
// taken and must only be made while no request is in flight.
module disk_scan_seek_timer_core import dsst_pkg::*; #(
    parameter int MAX_TRACKS  = DEFAULT_MAX_TRACKS,
    parameter int MAX_SECTORS = DEFAULT_MAX_SECTORS
) (
    input  logic        clk,
    input  logic        rst_n,
    dsst_req_if.sink    req,
    dsst_res_if.source  res,
    dsst_cfg_if.sink    cfg
);

    // The seven-bit sector register caps the effective sector count as well.
    localparam int SEC_CLAMP = (MAX_SECTORS > SEC_REG_MAX) ? SEC_REG_MAX : MAX_SECTORS;

    logic [NT_W-1:0]  num_tracks_reg;
    logic [NS_W-1:0]  num_sectors_reg;
    logic [DLY_W-1:0] trk_step_time_reg;
    logic [DLY_W-1:0] sector_delay_reg;
    logic [INC_W-1:0] sector_increment_reg;

    cfg_t cfg_eff;
    logic q_valid;
    logic q_ready;
    cmd_t q_push_data;
    logic b_valid;
    logic b_ready;
    cmd_t b_data;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_tracks_reg       <= NT_W'(32);
            num_sectors_reg      <= NS_W'(64);
            trk_step_time_reg    <= DLY_W'(256);
            sector_delay_reg     <= DLY_W'(16);
            sector_increment_reg <= INC_W'(16);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NUM_TRACKS:       num_tracks_reg       <= cfg.data[NT_W-1:0];
                REG_NUM_SECTORS:      num_sectors_reg      <= cfg.data[NS_W-1:0];
                REG_TRACK_DELAY:      trk_step_time_reg    <= cfg.data[DLY_W-1:0];
                REG_SECTOR_DELAY:     sector_delay_reg     <= cfg.data[DLY_W-1:0];
                REG_SECTOR_INCREMENT: sector_increment_reg <= cfg.data[INC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective geometry: saturate both counts into their legal ranges
    always_comb
    begin
        if (num_tracks_reg == '0)
        begin
            cfg_eff.tracks = NT_W'(1);
        end
        else if (num_tracks_reg > NT_W'(MAX_TRACKS))
        begin
            cfg_eff.tracks = NT_W'(MAX_TRACKS);
        end
        else
        begin
            cfg_eff.tracks = num_tracks_reg;
        end
        if (num_sectors_reg == '0)
        begin
            cfg_eff.secs = NS_W'(1);
        end
        else if (num_sectors_reg > NS_W'(SEC_CLAMP))
        begin
            cfg_eff.secs = NS_W'(SEC_CLAMP);
        end
        else
        begin
            cfg_eff.secs = num_sectors_reg;
        end
        cfg_eff.trk_step_time = trk_step_time_reg;
        cfg_eff.sector_delay  = sector_delay_reg;
        cfg_eff.inc_raw       = sector_increment_reg;
    end

    dsst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .cfg     (cfg_eff),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_push_data)
    );

    dsst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_valid),
        .push_ready (q_ready),
        .push_data  (q_push_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    dsst_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_eff),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_data  (b_data),
        .res     (res)
    );

endmodule
